// File: src/lif_neuron_isi_tracker_macros.svh
// assertion macros for the lif neuron interval tracker
`ifndef LIF_NEURON_ISI_TRACKER_MACROS_SVH
`define LIF_NEURON_ISI_TRACKER_MACROS_SVH

// same-cycle implication, checked on the rising edge of i_clk outside reset
`define LIF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LIF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lif_pkg.sv
`default_nettype none

package lif_pkg;

    // voltage format: signed, VOLT_FRAC_BITS fraction bits
    localparam int VOLT_FRAC_BITS = 16;
    localparam int CUR_SHIFT      = 28 - VOLT_FRAC_BITS;
    localparam int DT_SHIFT       = 16;

    // widths along the euler step
    localparam int P1_W = 49;                              // gain * current
    localparam int SC_W = P1_W - CUR_SHIFT;                // scaled current
    localparam int D_W  = ((SC_W > 33) ? SC_W : 33) + 2;   // derivative
    localparam int P2_W = D_W + 17;                        // derivative * dt
    localparam int ST_W = P2_W - DT_SHIFT;                 // voltage increment
    localparam int NV_W = ST_W + 1;                        // unsaturated voltage

    localparam logic signed [31:0] V_THRESH = 32'sd1 <<< VOLT_FRAC_BITS;

    // configuration register indexes
    localparam logic [1:0] REG_DRIVE_LEVEL = 2'd0;
    localparam logic [1:0] REG_NOISE_GAIN  = 2'd1;
    localparam logic [1:0] REG_TIME_STEP   = 2'd2;
    localparam logic [1:0] REG_REFRACTORY  = 2'd3;

    localparam logic [15:0] TIME_STEP_RST = 16'd655;

    typedef struct packed {
        logic load;     // input transfer, form gain * current
        logic mul;      // form derivative * dt
        logic update;   // commit neuron state, maybe emit a result
    } t_cmd;

    typedef struct packed {
        logic out_stall;  // result register full and not being taken
    } t_stat;

endpackage

`default_nettype wire

// File: src/lif_ctrl.sv
`default_nettype none

module lif_ctrl
    import lif_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       upd_go;

    assign upd_go     = (r_state == S_UPD) && !i_stat.out_stall;
    assign o_in_ready = (r_state == S_IDLE) || upd_go;

    assign o_cmd.load   = i_in_valid && o_in_ready;
    assign o_cmd.mul    = (r_state == S_MUL);
    assign o_cmd.update = upd_go;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (upd_go) n_state = o_cmd.load ? S_MUL : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

`default_nettype wire

// File: src/lif_datapath.sv
`default_nettype none

module lif_datapath
    import lif_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_wdata,
    input  wire logic signed [15:0] i_current_sample,
    input  wire logic               i_last_sample,
    input  wire logic               i_out_ready,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    output logic                    o_out_valid,
    output logic [31:0]             o_isi_count
);

    // configuration
    logic signed [31:0] r_drive;
    logic [31:0]        r_gain;
    logic [15:0]        r_dt;
    logic [15:0]        r_refr;

    // neuron state
    logic signed [31:0] r_v;
    logic [31:0]        r_cnt;
    logic [15:0]        r_refl;

    // pipeline registers
    logic signed [SC_W-1:0] r_scaled;
    logic                   r_last;
    logic signed [ST_W-1:0] r_step;
    logic                   r_out_valid;
    logic [31:0]            r_isi;

    logic signed [P1_W-1:0] p1;
    logic signed [D_W-1:0]  deriv;
    logic signed [P2_W-1:0] p2;
    logic signed [NV_W-1:0] nv;
    logic signed [31:0]     nv_sat;
    logic                   ovf;
    logic                   spike;
    logic                   active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= '0;
            r_gain  <= '0;
            r_dt    <= TIME_STEP_RST;
            r_refr  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DRIVE_LEVEL: r_drive <= $signed(i_cfg_wdata);
                REG_NOISE_GAIN:  r_gain  <= i_cfg_wdata;
                REG_TIME_STEP:   r_dt    <= i_cfg_wdata[15:0];
                REG_REFRACTORY:  r_refr  <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // first multiply straight from the input port, floor by arithmetic shift
    assign p1 = $signed({1'b0, r_gain}) * i_current_sample;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scaled <= SC_W'(p1 >>> CUR_SHIFT);
            r_last   <= i_last_sample;
        end
    end

    // -v + drive + scaled, then times dt
    assign deriv = D_W'(r_scaled) + D_W'(r_drive) - D_W'(r_v);
    assign p2    = deriv * $signed({1'b0, r_dt});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) r_step <= ST_W'(p2 >>> DT_SHIFT);
    end

    // new voltage, saturated to 32 bits
    assign nv  = NV_W'(r_step) + NV_W'(r_v);
    assign ovf = !((&nv[NV_W-1:31]) || !(|nv[NV_W-1:31]));
    always_comb begin
        if (ovf) nv_sat = nv[NV_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else     nv_sat = nv[31:0];
    end

    assign active = (r_refl == '0);
    assign spike  = active && (nv_sat >= V_THRESH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_cnt  <= '0;
            r_refl <= '0;
        end else if (i_cmd.update) begin
            if (r_last) begin
                r_v    <= '0;
                r_cnt  <= '0;
                r_refl <= '0;
            end else if (!active) begin
                r_refl <= r_refl - 16'd1;
            end else if (spike) begin
                r_v    <= '0;
                r_cnt  <= {16'd0, r_refr};
                r_refl <= r_refr;
            end else begin
                r_v <= nv_sat;
                if (r_cnt != '1) r_cnt <= r_cnt + 32'd1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                      r_out_valid <= 1'b0;
        else if (i_cmd.update && spike)    r_out_valid <= 1'b1;
        else if (i_out_ready)              r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && spike) r_isi <= r_cnt;
    end

    assign o_stat.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_isi_count      = r_isi;

endmodule

`default_nettype wire

// File: src/lif_neuron_isi_tracker.sv
// leaky integrate-and-fire neuron with interspike interval output
// input channel: i_in_valid / o_in_ready carry one current sample and a
//   last-sample flag; output channel: o_out_valid / i_out_ready carry the
//   interval count of a spike, zero or one result per input transfer
// config port: i_cfg_we writes i_cfg_wdata to the register at i_cfg_index
//   (0 drive level, 1 noise gain, 2 time step, 3 refractory samples); the
//   user must write only while the block is idle, which the block does not enforce
// order: the input register loads on the transfer, the step register after
//   it, and the result register with the state update if it spikes
// samples: the first multiply runs on the transfer cycle, the second from
//   the membrane voltage in the next, and the state update overlaps the
//   next transfer, so a new sample is taken before the last one is through;
//   the voltage feedback through the second multiply keeps a sample's multiply after the last update
// stall: the result register holds until taken; while it is full and not
//   taken the update stage waits and accepts no new sample while it waits
// reset: synchronous, active low; clears voltage, counter, refractory
//   count and the output valid, time step returns to 655, other config registers 0
`default_nettype none
`include "lif_neuron_isi_tracker_macros.svh"

module lif_neuron_isi_tracker
    import lif_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_wdata,
    // sample input
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_current_sample,
    input  wire logic               i_last_sample,
    // interval output
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [31:0]             o_isi_count
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: idle, second multiply, state update
    lif_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // euler step arithmetic, neuron state, config and result registers
    lif_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_current_sample (i_current_sample),
        .i_last_sample    (i_last_sample),
        .i_out_ready      (i_out_ready),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_isi_count      (o_isi_count)
    );

    // an accepted sample always goes to the second multiply next
    `LIF_ASSERT_NXT(a_load_then_mul, cmd.load, cmd.mul, "load not followed by multiply")
    // the update never overwrites a result still waiting
    `LIF_ASSERT_IMP(a_upd_no_stall, cmd.update, !(o_out_valid && !i_out_ready), "update during stall")
    // a result appears only from a state update
    `LIF_ASSERT_IMP(a_result_src, $rose(o_out_valid), $past(cmd.update), "result without update")
    // no transfer while multiplying
    `LIF_ASSERT_IMP(a_no_load_in_mul, cmd.mul, !o_in_ready, "ready high during multiply")

endmodule

`default_nettype wire

// File: bench/lif_isi_checker.sv
`timescale 1ns / 100ps

// predicts the interspike intervals of the neuron and checks every output transfer
module lif_isi_checker
    import lif_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [15:0] i_current_sample,
    input  logic               i_last_sample,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [31:0]        i_isi_count,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_spike_count,
    output int                 o_ignored_count
);

    localparam logic signed [63:0] VOLT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] VOLT_MIN = -64'sd2147483648;

    // register copies
    logic signed [31:0] drive_lvl;
    logic [31:0]        gain;
    logic [15:0]        dt;
    logic [15:0]        refr_len;

    // neuron state
    logic signed [31:0] volt;
    logic [31:0]        interval;
    logic [15:0]        refr_left;

    logic [31:0]        isi_expected[$];

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        o_fail_count++;
    endtask

    // one euler step, or one refractory sample
    task automatic advance_neuron(input logic signed [15:0] cur, input logic last);
        logic signed [63:0] cur64;
        logic signed [63:0] gain64;
        logic signed [63:0] dt64;
        logic signed [63:0] scaled;
        logic signed [63:0] deriv;
        logic signed [63:0] nv;
        cur64  = cur;
        gain64 = {32'd0, gain};
        dt64   = {48'd0, dt};
        if (refr_left != 16'd0) begin
            refr_left--;
            o_ignored_count++;
        end else begin
            scaled = (gain64 * cur64) >>> CUR_SHIFT;
            deriv  = 64'(drive_lvl) + scaled - 64'(volt);
            nv     = 64'(volt) + ((deriv * dt64) >>> DT_SHIFT);
            if (nv > VOLT_MAX) nv = VOLT_MAX;
            if (nv < VOLT_MIN) nv = VOLT_MIN;
            if (nv >= 64'(V_THRESH)) begin
                isi_expected = {isi_expected, interval};
                interval  = {16'd0, refr_len};
                volt      = '0;
                refr_left = refr_len;
            end else begin
                volt = nv[31:0];
                if (interval != 32'hFFFF_FFFF) interval++;
            end
        end
        if (last) begin
            volt      = '0;
            interval  = '0;
            refr_left = '0;
        end
    endtask

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_spike_count   = 0;
        o_ignored_count = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drive_lvl = '0;
            gain      = '0;
            dt        = TIME_STEP_RST;
            refr_len  = '0;
            volt      = '0;
            interval  = '0;
            refr_left = '0;
            isi_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DRIVE_LEVEL: drive_lvl = i_cfg_wdata;
                    REG_NOISE_GAIN:  gain      = i_cfg_wdata;
                    REG_TIME_STEP:   dt        = i_cfg_wdata[15:0];
                    REG_REFRACTORY:  refr_len  = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (isi_expected.size() == 0) begin
                    report_mismatch($sformatf("isi_count %0d with no spike expected",
                                              i_isi_count));
                end else begin
                    if (i_isi_count !== isi_expected[0])
                        report_mismatch($sformatf("isi_count %0d, expected %0d",
                                                  i_isi_count, isi_expected[0]));
                    void'(isi_expected.pop_front());
                    o_spike_count++;
                end
            end
            if (i_in_valid && i_in_ready)
                advance_neuron(i_current_sample, i_last_sample);
        end
        o_pending = isi_expected.size();
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lif_pkg::*;

    // cycles with no transfer and no register write before the run is abandoned
    localparam int STALL_LIMIT  = 400;
    // the block can still be busy on a sample without a spike when nothing is pending
    localparam int PIPE_SETTLE  = 8;
    localparam int END_SETTLE   = 10;
    localparam int TYPICAL_ITEMS = 85;
    localparam int WIDE_ITEMS    = 40;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_we         = 1'b0;
    logic [1:0]         cfg_index      = REG_DRIVE_LEVEL;
    logic [31:0]        cfg_wdata      = '0;
    logic               in_valid       = 1'b0;
    logic               in_ready;
    logic signed [15:0] current_sample = '0;
    logic               last_sample    = 1'b0;
    logic               out_valid;
    logic               out_ready      = 1'b0;
    logic [31:0]        isi_count;

    int fail_count;
    int pending;
    int spike_count;
    int ignored_count;

    int idle_cycles    = 0;
    int samples_sent   = 0;
    int run_ends       = 0;
    int settings_used  = 0;
    bit sender_burst   = 1'b0;
    bit receiver_burst = 1'b0;

    always #10 clk = ~clk;

    lif_neuron_isi_tracker dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_current_sample (current_sample),
        .i_last_sample    (last_sample),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_isi_count      (isi_count)
    );

    lif_isi_checker isi_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_current_sample (current_sample),
        .i_last_sample    (last_sample),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_isi_count      (isi_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_spike_count    (spike_count),
        .o_ignored_count  (ignored_count)
    );

    // one register write per falling edge, write enable left high for back-to-back writes
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    // every register of the block, block must be idle
    task automatic set_config(input logic [31:0] drive, input logic [31:0] gain,
                              input logic [15:0] dt, input logic [15:0] refr);
        write_reg(REG_DRIVE_LEVEL, drive);
        write_reg(REG_NOISE_GAIN, gain);
        write_reg(REG_TIME_STEP, {16'd0, dt});
        write_reg(REG_REFRACTORY, {16'd0, refr});
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // one sample transfer, preceded by a random gap unless the sender is in a burst
    task automatic send_sample(input logic [15:0] cur, input logic last);
        int gap;
        if ($urandom_range(0, 19) == 0) sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        current_sample <= cur;
        last_sample    <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        samples_sent++;
        if (last) run_ends++;
    endtask

    // stop sending, let every expected spike come out and the pipe empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (PIPE_SETTLE) @(negedge clk);
    endtask

    // receiver: per result a random stall, then ready held until the transfer
    initial begin
        int stall;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 14) == 0) receiver_burst = !receiver_burst;
            stall = receiver_burst ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // watchdog: any transfer or register write restarts the count
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] drive;
        logic [31:0] gain;
        logic [15:0] dt;
        logic [15:0] refr;
        logic [15:0] cur;
        bit          wide;
        int          n_items;
        int          last_odds;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: no drive and no gain, the voltage stays at zero
        send_sample(16'h0000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        wait_idle();

        // full drive and gain: voltage saturates both ways, every step but the negative full-scale one spikes
        set_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b1);
        wait_idle();

        // refractory of three: spike, three ignored, spike, run end cuts the period short
        set_config(32'h7FFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'd3);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h1234, 1'b1);
        send_sample(16'h0000, 1'b0);
        wait_idle();

        // zero time step: voltage frozen, counter just counts
        set_config(32'h8000_0000, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        wait_idle();

        // longest refractory period, only a run end gets out of it
        set_config(32'h0001_8000, 32'h0001_0000, 16'hFFFF, 16'hFFFF);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0000, 1'b0);
        wait_idle();

        // random phases: mostly lively settings that spike often, some fully random ones
        for (int phase = 0; phase < 11; phase++) begin
            wide = (phase % 4 == 1);
            if (wide) begin
                drive     = $urandom;
                gain      = $urandom;
                dt        = 16'($urandom);
                refr      = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 20));
                n_items   = WIDE_ITEMS;
                last_odds = 5;
            end else begin
                drive = $urandom_range(32'h0000_C000, 32'h0003_0000);
                if ($urandom_range(0, 4) == 0) drive = -drive;
                gain      = $urandom_range(0, 32'h0003_0000);
                dt        = 16'($urandom_range(16'h1000, 16'hFFFF));
                refr      = 16'($urandom_range(0, 6));
                n_items   = TYPICAL_ITEMS;
                last_odds = 49;
            end
            set_config(drive, gain, dt, refr);
            for (int k = 0; k < n_items; k++) begin
                cur = 16'($urandom);
                if ($urandom_range(0, 15) == 0) cur = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                send_sample(cur, $urandom_range(0, last_odds) == 0);
            end
            wait_idle();
        end

        // final drain, then a settling wait of END_SETTLE for any stray transfer to show up
        while (pending != 0) @(negedge clk);
        repeat (END_SETTLE) @(negedge clk);

        $display("summary: %0d samples under %0d register settings, %0d spikes checked",
                 samples_sent, settings_used, spike_count);
        $display("summary: %0d samples fell in refractory periods, %0d run ends",
                 ignored_count, run_ends);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
